/* rtl/mavtc_pkg.sv */
// Shared types, constants and helpers for the moving-average threat classifier.
// No dependencies; every other file in the block imports this package.
`default_nettype none

package mavtc_pkg;

    // Q1.10 confidence and threshold format.
    localparam int CONF_W   = 11;
    localparam int Q_ONE    = 1024;
    // Signed margin (main - clutter) needs one bit more than a confidence.
    localparam int MARGIN_W = CONF_W + 1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_WARMUP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_MARGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DANGER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAUTION    = 3'd4;

    // Register reset values (0.6, 0.5, 0.2, 0.8, 0.4 in Q1.10).
    localparam logic [CONF_W-1:0] RST_WARMUP     = 11'd614;
    localparam logic [CONF_W-1:0] RST_LOW_MARGIN = 11'd512;
    localparam logic [CONF_W-1:0] RST_MARGIN_MIN = 11'd205;
    localparam logic [CONF_W-1:0] RST_DANGER     = 11'd819;
    localparam logic [CONF_W-1:0] RST_CAUTION    = 11'd410;

    // Threat level codes.
    typedef enum logic [1:0] {
        LVL_SAFE    = 2'd0,
        LVL_CAUTION = 2'd1,
        LVL_DANGER  = 2'd2
    } t_level;

    // Threshold set handed from the register file to the classifier.
    typedef struct packed {
        logic [CONF_W-1:0] warmup;
        logic [CONF_W-1:0] low_margin;
        logic [CONF_W-1:0] margin_min;
        logic [CONF_W-1:0] danger;
        logic [CONF_W-1:0] caution;
    } t_cfg;

    // Clamp a confidence to 1.0.
    function automatic logic [CONF_W-1:0] sat_q(input logic [CONF_W-1:0] v);
        logic [CONF_W-1:0] res;
        res = (v > CONF_W'(Q_ONE)) ? CONF_W'(Q_ONE) : v;
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/moving_average_threat_classifier.sv */
// Moving-average threat classifier: takes one word per clock and returns one threat level per
// word, sustained unless the output stalls. The first stage is the shift-register window with
// its running sum and fill count; the second multiplies each threshold by the fill count and
// grades the sum against those products. Input tdata packs main_confidence in bits 10:0 and
// clutter_confidence in bits 21:11; confidences above 1.0 are clamped. Thresholds (0 warm-up,
// 1 low-margin, 2 margin minimum, 3 danger, 4 caution) are written over the configuration
// channel; the user must do so only while the block is idle, as the block does not enforce it.
`default_nettype none

module moving_average_threat_classifier #(
    parameter int WINDOW = 5
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // Input stream.
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  wire  [23:0]                      i_s_axis_tdata,  // main_confidence, clutter_confidence
    // Output stream.
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    output logic [7:0]                       o_m_axis_tdata,  // threat_level
    // Configuration write channel.
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [mavtc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [mavtc_pkg::CONF_W-1:0]     i_cfg_data
);
    import mavtc_pkg::*;

    localparam int SUM_W = $clog2(1024*WINDOW+1);
    localparam int CNT_W = $clog2(WINDOW+1);

    t_cfg                       w_cfg;
    logic                       w_a_valid;
    logic                       w_b_ready;
    logic [SUM_W-1:0]           w_sum;
    logic [CNT_W-1:0]           w_cnt;
    logic signed [MARGIN_W-1:0] w_margin;
    t_level                     w_level;

    // Threshold registers.
    mavtc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Window and running sum.
    mavtc_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_main    (i_s_axis_tdata[CONF_W-1:0]),
        .i_clutter (i_s_axis_tdata[2*CONF_W-1:CONF_W]),
        .o_valid   (w_a_valid),
        .i_ready   (w_b_ready),
        .o_sum     (w_sum),
        .o_cnt     (w_cnt),
        .o_margin  (w_margin)
    );

    // Grading and result register.
    mavtc_classify #(
        .WINDOW (WINDOW)
    ) u_classify (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_a_valid),
        .o_ready  (w_b_ready),
        .i_sum    (w_sum),
        .i_cnt    (w_cnt),
        .i_margin (w_margin),
        .i_cfg    (w_cfg),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_level  (w_level)
    );

    assign o_m_axis_tdata = {6'b000000, w_level};

endmodule

`default_nettype wire

/* rtl/mavtc_cfg.sv */
// Threshold register file of the threat classifier.
// Depends on mavtc_pkg for the register indexes, reset values and t_cfg.
`default_nettype none

module mavtc_cfg (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [mavtc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [mavtc_pkg::CONF_W-1:0]     i_cfg_data,
    output mavtc_pkg::t_cfg                  o_cfg
);
    import mavtc_pkg::*;

    t_cfg r_cfg;

    // Writes are always taken; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warmup     <= RST_WARMUP;
            r_cfg.low_margin <= RST_LOW_MARGIN;
            r_cfg.margin_min <= RST_MARGIN_MIN;
            r_cfg.danger     <= RST_DANGER;
            r_cfg.caution    <= RST_CAUTION;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WARMUP:     r_cfg.warmup     <= i_cfg_data;
                REG_LOW_MARGIN: r_cfg.low_margin <= i_cfg_data;
                REG_MARGIN_MIN: r_cfg.margin_min <= i_cfg_data;
                REG_DANGER:     r_cfg.danger     <= i_cfg_data;
                REG_CAUTION:    r_cfg.caution    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/mavtc_window.sv */
// Sample delay line, running sum and fill count of the threat classifier.
// Depends on mavtc_pkg; its sum and count registers also form the first pipeline stage.
`default_nettype none

module mavtc_window #(
    parameter int WINDOW = 5
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire  [mavtc_pkg::CONF_W-1:0]        i_main,
    input  wire  [mavtc_pkg::CONF_W-1:0]        i_clutter,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic [$clog2(1024*WINDOW+1)-1:0]    o_sum,
    output logic [$clog2(WINDOW+1)-1:0]         o_cnt,
    output logic signed [mavtc_pkg::MARGIN_W-1:0] o_margin
);
    import mavtc_pkg::*;

    localparam int SUM_W = $clog2(1024*WINDOW+1);
    localparam int CNT_W = $clog2(WINDOW+1);

    logic [CONF_W-1:0]          r_taps [WINDOW];
    logic [SUM_W-1:0]           r_sum;
    logic [SUM_W-1:0]           n_sum;
    logic [CNT_W-1:0]           r_cnt;
    logic [CNT_W-1:0]           n_cnt;
    logic signed [MARGIN_W-1:0] r_margin;
    logic signed [MARGIN_W-1:0] n_margin;
    logic                       r_valid;
    logic [CONF_W-1:0]          w_main;
    logic [CONF_W-1:0]          w_clutter;
    logic                       w_full;
    logic                       w_accept;

    // The stage can take a word when it is empty or its word moves on.
    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // Saturated inputs, signed margin and running-sum update.
    always_comb begin
        w_main    = sat_q(i_main);
        w_clutter = sat_q(i_clutter);
        w_full    = (r_cnt == CNT_W'(WINDOW));
        n_margin  = $signed({1'b0, w_main}) - $signed({1'b0, w_clutter});
        n_sum     = r_sum + SUM_W'(w_main);
        if (w_full) begin
            n_sum = n_sum - SUM_W'(r_taps[WINDOW-1]);
        end
        n_cnt = w_full ? r_cnt : r_cnt + 1'b1;
    end

    // Delay line: the last tap is the sample that leaves a full window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_taps[i] <= '0;
            end
        end else if (w_accept) begin
            r_taps[0] <= w_main;
            for (int i = 1; i < WINDOW; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
        end
    end

    // Running state, which doubles as the stage output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    // Margin travels with its word.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_margin <= n_margin;
        end
    end

    assign o_valid  = r_valid;
    assign o_sum    = r_sum;
    assign o_cnt    = r_cnt;
    assign o_margin = r_margin;

endmodule

`default_nettype wire

/* rtl/mavtc_classify.sv */
// Threshold grading of the window average, compared by cross-multiplication.
// Depends on mavtc_pkg; holds the result register that drives the output stream.
`default_nettype none

module mavtc_classify #(
    parameter int WINDOW = 5
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire  [$clog2(1024*WINDOW+1)-1:0]      i_sum,
    input  wire  [$clog2(WINDOW+1)-1:0]           i_cnt,
    input  wire  signed [mavtc_pkg::MARGIN_W-1:0] i_margin,
    input  mavtc_pkg::t_cfg                       i_cfg,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output mavtc_pkg::t_level                     o_level
);
    import mavtc_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW+1);
    localparam int PROD_W = CONF_W + CNT_W;

    logic [PROD_W-1:0] w_sum;
    logic [PROD_W-1:0] w_warm_lim;
    logic [PROD_W-1:0] w_low_lim;
    logic [PROD_W-1:0] w_dang_lim;
    logic [PROD_W-1:0] w_caut_lim;
    logic              w_low_margin;
    t_level            n_level;
    t_level            r_level;
    logic              r_valid;

    assign o_ready = !r_valid || i_ready;

    // Threshold times count against the sum: avg > T is sum > T * count.
    always_comb begin
        w_sum        = PROD_W'(i_sum);
        w_warm_lim   = PROD_W'(i_cfg.warmup) * PROD_W'(i_cnt);
        w_low_lim    = PROD_W'(i_cfg.low_margin) * PROD_W'(i_cnt);
        w_dang_lim   = PROD_W'(i_cfg.danger) * PROD_W'(i_cnt);
        w_caut_lim   = PROD_W'(i_cfg.caution) * PROD_W'(i_cnt);
        w_low_margin = $signed({i_margin[MARGIN_W-1], i_margin})
                     < $signed({2'b00, i_cfg.margin_min});
        if (i_cnt != CNT_W'(WINDOW)) begin
            n_level = (w_sum > w_warm_lim) ? LVL_CAUTION : LVL_SAFE;
        end else if (w_low_margin) begin
            n_level = (w_sum > w_low_lim) ? LVL_CAUTION : LVL_SAFE;
        end else if (w_sum >= w_dang_lim) begin
            n_level = LVL_DANGER;
        end else if (w_sum >= w_caut_lim) begin
            n_level = LVL_CAUTION;
        end else begin
            n_level = LVL_SAFE;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_level <= n_level;
        end
    end

    assign o_valid = r_valid;
    assign o_level = r_level;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for moving_average_threat_classifier.
// Drives confidence words and threshold writes, predicts every threat level in a scoreboard
// class and compares it with the output stream. Depends only on rtl/mavtc_pkg.sv and the RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    import mavtc_pkg::*;

    localparam int WINDOW       = 5;
    localparam int CONF_MAX     = (1 << CONF_W) - 1;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    // Indexes 5 to 7 are not mapped to any register.
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNMAPPED = 3'd5;
    localparam int                   UNMAPPED_COUNT     = 3;

    // Tracks thresholds and window state and holds the expected threat levels in order.
    class threat_scoreboard;
        logic [CONF_W-1:0] warmup;
        logic [CONF_W-1:0] low_margin;
        logic [CONF_W-1:0] margin_min;
        logic [CONF_W-1:0] danger;
        logic [CONF_W-1:0] caution;
        logic [CONF_W-1:0] samples [WINDOW];
        int                sample_sum;
        int                fill;
        int                wr_pos;
        t_level            level_q [$];
        int                errors;

        function new();
            warmup     = RST_WARMUP;
            low_margin = RST_LOW_MARGIN;
            margin_min = RST_MARGIN_MIN;
            danger     = RST_DANGER;
            caution    = RST_CAUTION;
            foreach (samples[i]) samples[i] = '0;
            sample_sum = 0;
            fill       = 0;
            wr_pos     = 0;
            errors     = 0;
        endfunction

        // Mirror a register write; unmapped indexes change nothing.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CONF_W-1:0] value);
            case (idx)
                REG_WARMUP:     warmup = value;
                REG_LOW_MARGIN: low_margin = value;
                REG_MARGIN_MIN: margin_min = value;
                REG_DANGER:     danger = value;
                REG_CAUTION:    caution = value;
                default: ;
            endcase
        endfunction

        // Push one word through the window and queue the level it must produce.
        function void note_word(logic [CONF_W-1:0] main_raw, logic [CONF_W-1:0] clutter_raw);
            int     m;
            int     c;
            int     margin;
            t_level lvl;
            m = (main_raw > Q_ONE) ? Q_ONE : int'(main_raw);
            c = (clutter_raw > Q_ONE) ? Q_ONE : int'(clutter_raw);
            if (fill >= WINDOW) begin
                sample_sum -= int'(samples[wr_pos]);
            end
            samples[wr_pos] = CONF_W'(m);
            sample_sum += m;
            wr_pos = (wr_pos + 1 >= WINDOW) ? 0 : wr_pos + 1;
            if (fill < WINDOW) begin
                fill++;
            end
            margin = m - c;
            // Averages are compared by cross-multiplying with the fill count.
            if (fill < WINDOW) begin
                lvl = (sample_sum > int'(warmup) * fill) ? LVL_CAUTION : LVL_SAFE;
            end else if (margin < int'(margin_min)) begin
                lvl = (sample_sum > int'(low_margin) * fill) ? LVL_CAUTION : LVL_SAFE;
            end else if (sample_sum >= int'(danger) * fill) begin
                lvl = LVL_DANGER;
            end else if (sample_sum >= int'(caution) * fill) begin
                lvl = LVL_CAUTION;
            end else begin
                lvl = LVL_SAFE;
            end
            level_q.insert(level_q.size(), lvl);
        endfunction

        // Compare one output word with the oldest expected level.
        function void check_level(logic [1:0] actual);
            t_level want;
            if (level_q.size() == 0) begin
                $error("threat_level: output word with nothing expected, actual %0d", actual);
                errors++;
            end else begin
                want = level_q[0];
                level_q.delete(0);
                if (actual !== want) begin
                    $error("threat_level mismatch: expected %0d, actual %0d", want, actual);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return level_q.size();
        endfunction
    endclass

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic [23:0]          i_s_axis_tdata  = '0;
    logic                 i_m_axis_tready = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [CONF_W-1:0]    i_cfg_data      = '0;
    wire                  o_s_axis_tready;
    wire                  o_m_axis_tvalid;
    wire  [7:0]           o_m_axis_tdata;
    wire                  o_cfg_ready;

    threat_scoreboard sb;
    bit  gaps_on       = 1'b0;
    bit  long_hold_req = 1'b0;
    int  cycle_count   = 0;

    moving_average_threat_classifier #(
        .WINDOW(WINDOW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Give up if the run hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("moving_average_threat_classifier test failed");
            $finish;
        end
    end

    // Every accepted output word is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_level(o_m_axis_tdata[1:0]);
        end
    end

    // Output side: random stall bursts, plus one long hold when requested.
    initial begin : sink
        int n;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 17);
                i_m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one confidence word and wait until it is taken. Valid stays high afterwards.
    task automatic send_word(input logic [CONF_W-1:0] main_val,
                             input logic [CONF_W-1:0] clutter_val);
        int n;
        if (gaps_on && $urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 17);
            i_s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, clutter_val, main_val};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_word(main_val, clutter_val);
    endtask

    // Single register write; the caller lowers valid after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CONF_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, value);
    endtask

    // Load all five thresholds, preceded by a write to an unmapped index that must be ignored.
    task automatic program_regs(input logic [CONF_W-1:0] w, input logic [CONF_W-1:0] lm,
                                input logic [CONF_W-1:0] mm, input logic [CONF_W-1:0] d,
                                input logic [CONF_W-1:0] c);
        write_reg(REG_FIRST_UNMAPPED + CFG_IDX_W'($urandom_range(0, UNMAPPED_COUNT - 1)),
                  CONF_W'($urandom_range(0, CONF_MAX)));
        write_reg(REG_WARMUP, w);
        write_reg(REG_LOW_MARGIN, lm);
        write_reg(REG_MARGIN_MIN, mm);
        write_reg(REG_DANGER, d);
        write_reg(REG_CAUTION, c);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop offering words and wait for the pipeline to empty.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CONF_W-1:0] to_conf(input int v);
        return (v < 0) ? '0 : (v > CONF_MAX) ? CONF_W'(CONF_MAX) : CONF_W'(v);
    endfunction

    // Runs of words held near a threshold so the averages sit on the decision edges,
    // mixed with fully random words and clutter placed around the margin minimum.
    task automatic run_random(input int n_words);
        int left;
        int run_len;
        int target;
        int mv;
        int cv;
        left    = n_words;
        run_len = 0;
        target  = 0;
        while (left > 0) begin
            if (run_len == 0) begin
                run_len = $urandom_range(3, 12);
                case ($urandom_range(0, 5))
                    0:       target = int'(sb.danger);
                    1:       target = int'(sb.caution);
                    2:       target = int'(sb.warmup);
                    3:       target = int'(sb.low_margin);
                    default: target = $urandom_range(0, Q_ONE);
                endcase
            end
            if ($urandom_range(0, 7) == 0) begin
                mv = $urandom_range(0, CONF_MAX);
            end else begin
                mv = target + int'($urandom_range(0, 16)) - 8;
            end
            case ($urandom_range(0, 7))
                0:       cv = $urandom_range(0, CONF_MAX);
                1, 2, 3: cv = mv - int'(sb.margin_min) + int'($urandom_range(0, 4)) - 2;
                default: cv = $urandom_range(0, Q_ONE);
            endcase
            send_word(to_conf(mv), to_conf(cv));
            run_len--;
            left--;
        end
    endtask

    initial begin : stimulus
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset thresholds: warm-up edges, saturation, negative margin, margin exactly at
        // the minimum, danger and caution exactly at their thresholds, and the safe band.
        send_word(11'd614, 11'd0);
        send_word(11'd615, 11'd0);
        send_word(11'd0, 11'd0);
        send_word(11'd2047, 11'd0);
        send_word(11'd1025, 11'd1025);
        send_word(11'd819, 11'd2047);
        send_word(11'd819, 11'd0);
        send_word(11'd819, 11'd0);
        send_word(11'd819, 11'd0);
        send_word(11'd819, 11'd0);
        send_word(11'd819, 11'd614);
        send_word(11'd819, 11'd615);
        send_word(11'd410, 11'd0);
        send_word(11'd410, 11'd0);
        send_word(11'd410, 11'd0);
        send_word(11'd410, 11'd0);
        send_word(11'd410, 11'd0);
        send_word(11'd409, 11'd0);
        send_word(11'd0, 11'd1024);
        send_word(11'd1024, 11'd1024);
        send_word(11'd1365, 11'd682);
        drain();

        gaps_on = 1'b1;

        // All thresholds at zero.
        program_regs('0, '0, '0, '0, '0);
        run_random(200);
        drain();

        // All thresholds above 1.0, at the top of the register range.
        program_regs(11'd2047, 11'd2047, 11'd2047, 11'd2047, 11'd2047);
        run_random(200);
        drain();

        // All thresholds at exactly 1.0.
        program_regs(11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024);
        run_random(200);
        drain();

        // Random thresholds inside the Q1.10 range, with a long output hold so the
        // pipeline fills up and back-pressures the input.
        program_regs(CONF_W'($urandom_range(0, Q_ONE)), CONF_W'($urandom_range(0, Q_ONE)),
                     CONF_W'($urandom_range(0, Q_ONE)), CONF_W'($urandom_range(0, Q_ONE)),
                     CONF_W'($urandom_range(0, Q_ONE)));
        long_hold_req = 1'b1;
        run_random(220);
        drain();

        // Random thresholds over the whole register range.
        program_regs(CONF_W'($urandom_range(0, CONF_MAX)), CONF_W'($urandom_range(0, CONF_MAX)),
                     CONF_W'($urandom_range(0, CONF_MAX)), CONF_W'($urandom_range(0, CONF_MAX)),
                     CONF_W'($urandom_range(0, CONF_MAX)));
        run_random(220);
        drain();

        // Back to the reset thresholds, at full rate with no idling on either side.
        gaps_on = 1'b0;
        program_regs(RST_WARMUP, RST_LOW_MARGIN, RST_MARGIN_MIN, RST_DANGER, RST_CAUTION);
        run_random(300);
        drain();

        if (sb.errors == 0) begin
            $display("moving_average_threat_classifier test passed");
        end else begin
            $display("moving_average_threat_classifier test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
